// ===== hw/rtl/bsml_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsml_pkg;

  // default bitmap store depth in bytes
  localparam int unsigned MaxMapBytes = 4096;

  // stream field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 32;

  // input tdata: data_byte, block_records
  localparam int unsigned InDataW  = ByteW + CountW;
  // output tdata: write_addr, write_data
  localparam int unsigned OutDataW = 2 * WordW;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_sparse_memory_loader.sv =====
// bitmap sparse memory loader
//
// input channel s_axis: one item per byte of a decompressed load stream. tdata carries the
// stream byte and the record count of a block, tuser flags the first byte of a block.
// output channel m_axis: one item per 64-bit memory write (address and data in tdata), or
// one item with tuser high when a bitmap is longer than the bitmap store; the rest of
// that block is then skipped.
// throughput: one byte per cycle, unless a waiting result holds the input, while addresses,
// spans, bitmap bytes and data words are gathered. after the last bitmap byte, and whenever
// the remaining bits of the current bitmap byte are clear, the bitmap store is scanned
// through its single read port, one byte per cycle, and the input stalls for the whole scan.
// a search scans at most the bytes of the current map.
// output: a write item is registered and appears in the cycle after its data word's eighth byte.
// reset: parser returns to idle and ignores bytes until a block start; the output holds
// no item. the bitmap store is not cleared, only bytes written for the current record
// are read back.
// stall: a waiting result holds in the output register; the input keeps flowing and
// only stops on the last byte of a span or data word, which may produce the next result.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_sparse_memory_loader #(
  parameter int unsigned MAX_MAP_BYTES = bsml_pkg::MaxMapBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // s_axis_tdata: data_byte [7:0], block_records [39:8]
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [bsml_pkg::InDataW-1:0]  s_axis_tdata,
  // s_axis_tuser: block_start
  input  wire logic                          s_axis_tuser,
  // m_axis_tdata: write_addr [63:0], write_data [127:64]
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [bsml_pkg::OutDataW-1:0] m_axis_tdata,
  // m_axis_tuser: map_overflow
  output logic                               m_axis_tuser
);

  localparam int unsigned IdxW = (MAX_MAP_BYTES > 1) ? $clog2(MAX_MAP_BYTES) : 1;
  localparam int unsigned LenW = $clog2(MAX_MAP_BYTES + 1);
  localparam int unsigned ByteW = bsml_pkg::ByteW;
  localparam int unsigned WordW = bsml_pkg::WordW;
  localparam int unsigned CountW = bsml_pkg::CountW;
  localparam int unsigned SpanW = WordW - 6;

  // parse phases
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhAddr = 3'd1;
  localparam logic [2:0] PhSpan = 3'd2;
  localparam logic [2:0] PhMap  = 3'd3;
  localparam logic [2:0] PhSeek = 3'd4;
  localparam logic [2:0] PhData = 3'd5;

  // first set bit of v at or above position from: {found, index}
  function automatic logic [3:0] first_set(input logic [7:0] v, input logic [3:0] from);
    logic [3:0] res;
    res = 4'b0;
    for (int m = 7; m >= 0; m--) begin
      if (v[m] && (m >= int'(from))) begin
        res = {1'b1, 3'(m)};
      end
    end
    return res;
  endfunction

  logic [2:0]        phase_q, phase_d;
  logic [2:0]        pos_q, pos_d;
  logic [WordW-1:0]  asm_q, asm_d;
  logic [WordW-1:0]  base_q, base_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   scan_q, scan_d;      // map write index, then scan read index
  logic              pend_q, pend_d;      // scan read in flight
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]   byte_idx_q, byte_idx_d;
  logic [2:0]        bit_q, bit_d;
  logic [ByteW-1:0]  cur_byte_q, cur_byte_d;
  logic [CountW-1:0] recs_q, recs_d;
  logic                         out_valid_q, out_valid_d;
  logic [bsml_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                         out_user_q, out_user_d;

  // bitmap store port
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  logic              in_acc;
  logic [ByteW-1:0]  in_byte;
  logic              in_start;
  logic [CountW-1:0] in_recs;
  logic [CountW-1:0] recs_dec;
  logic [2:0]        fin_phase;
  logic [2:0]        eff_phase;
  logic [2:0]        eff_pos;
  logic [WordW-1:0]  word;
  logic [SpanW-1:0]  span_len;
  logic [3:0]        seek_hit;
  logic [3:0]        next_hit;
  logic              out_blocked;

  assign in_byte  = s_axis_tdata[ByteW-1:0];
  assign in_recs  = s_axis_tdata[ByteW +: CountW];
  assign in_start = s_axis_tuser;

  // hold the input only on a byte that may complete a result while one still waits
  assign out_blocked = out_valid_q && !m_axis_tready && (pos_q == 3'd7)
                       && ((phase_q == PhData) || (phase_q == PhSpan));
  assign s_axis_tready = (phase_q != PhSeek) && !out_blocked;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign recs_dec  = (recs_q != '0) ? recs_q - CountW'(1) : '0;
  assign fin_phase = (recs_dec != '0) ? PhAddr : PhIdle;

  assign word     = {in_byte, asm_q[WordW-ByteW-1:0]};
  assign span_len = word[WordW-1:6];
  assign seek_hit = first_set(ram_rdata, 4'd0);
  assign next_hit = first_set(cur_byte_q, {1'b0, bit_q} + 4'd1);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    asm_d      = asm_q;
    base_d     = base_q;
    len_d      = len_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    byte_idx_d = byte_idx_q;
    bit_d      = bit_q;
    cur_byte_d = cur_byte_q;
    recs_d     = recs_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    ram_we    = 1'b0;
    ram_waddr = scan_q[IdxW-1:0];
    ram_re    = 1'b0;
    ram_raddr = scan_q[IdxW-1:0];
    eff_phase = in_start ? ((in_recs != '0) ? PhAddr : PhIdle) : phase_q;
    eff_pos   = in_start ? 3'd0 : pos_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (phase_q == PhSeek) begin
      // scan the bitmap store for the next set bit, one byte per cycle
      if (pend_q && seek_hit[3]) begin
        byte_idx_d = pend_idx_q;
        bit_d      = seek_hit[2:0];
        cur_byte_d = ram_rdata;
        pend_d     = 1'b0;
        phase_d    = PhData;
      end else if (scan_q < len_q) begin
        ram_re     = 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = scan_q[IdxW-1:0];
        scan_d     = scan_q + LenW'(1);
      end else begin
        pend_d  = 1'b0;
        recs_d  = recs_dec;
        phase_d = fin_phase;
      end
    end else if (in_acc) begin
      if (in_start) begin
        recs_d  = in_recs;
        phase_d = eff_phase;
      end
      pos_d = eff_pos;
      case (eff_phase)
        PhMap: begin
          ram_we = 1'b1;
          scan_d = scan_q + LenW'(1);
          if ((scan_q + LenW'(1)) >= len_q) begin
            scan_d  = '0;
            pend_d  = 1'b0;
            phase_d = PhSeek;
          end
        end
        PhAddr, PhSpan, PhData: begin
          asm_d[{eff_pos, 3'b000} +: ByteW] = in_byte;
          pos_d = eff_pos + 3'd1;
          if (eff_pos == 3'd7) begin
            case (eff_phase)
              PhAddr: begin
                if (word == '0) begin
                  phase_d = PhIdle;
                end else begin
                  base_d  = word;
                  phase_d = PhSpan;
                end
              end
              PhSpan: begin
                if (span_len > SpanW'(MAX_MAP_BYTES)) begin
                  // bitmap too long: report and skip the block
                  phase_d     = PhIdle;
                  out_valid_d = 1'b1;
                  out_data_d  = '0;
                  out_user_d  = 1'b1;
                end else begin
                  len_d  = span_len[LenW-1:0];
                  scan_d = '0;
                  pend_d = 1'b0;
                  if (span_len == '0) begin
                    recs_d  = recs_dec;
                    phase_d = fin_phase;
                  end else begin
                    phase_d = PhMap;
                  end
                end
              end
              default: begin
                // data word complete: write to base + byte*64 + bit*8
                out_valid_d = 1'b1;
                out_user_d  = 1'b0;
                out_data_d  = {word,
                               base_q + {{(WordW-IdxW-6){1'b0}}, byte_idx_q, bit_q, 3'b000}};
                if (next_hit[3]) begin
                  bit_d = next_hit[2:0];
                end else begin
                  scan_d  = LenW'(byte_idx_q) + LenW'(1);
                  pend_d  = 1'b0;
                  phase_d = PhSeek;
                end
              end
            endcase
          end
        end
        default: begin
          // idle: byte ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      pos_q       <= '0;
      base_q      <= '0;
      len_q       <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      byte_idx_q  <= '0;
      bit_q       <= '0;
      recs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      base_q      <= base_d;
      len_q       <= len_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      byte_idx_q  <= byte_idx_d;
      bit_q       <= bit_d;
      recs_q      <= recs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    asm_q      <= asm_d;
    pend_idx_q <= pend_idx_d;
    cur_byte_q <= cur_byte_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  bsml_bitmap_ram #(
    .Depth (MAX_MAP_BYTES),
    .AddrW (IdxW)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bsml_bitmap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsml_bitmap_ram #(
  parameter int unsigned Depth = bsml_pkg::MaxMapBytes,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [bsml_pkg::ByteW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [bsml_pkg::ByteW-1:0] rdata_o
);

  logic [bsml_pkg::ByteW-1:0] mem_q [Depth];
  logic [bsml_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, updated only when re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QuietLimit  = 20000;  // cycles with no item moving on either side
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned LiveTarget  = 1100;   // parsed bytes wanted in all
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DirRows     = 29;

  // parser phases of the load stream
  typedef enum logic [2:0] {LP_IDLE, LP_ADDR, LP_SPAN, LP_MAP, LP_DATA} load_phase_e;

  // how bitmap bytes are filled by the generator
  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_SPARSE, FILL_ENDS} map_fill_e;

  // one memory write or overflow item as seen on m_axis
  typedef struct packed {
    logic        ovf;
    logic [63:0] data;
    logic [63:0] addr;
  } write_t;

  // one stream byte with its side fields, plus an optional typed-in result
  typedef struct packed {
    logic        typed;
    write_t      want;
    logic [31:0] recs;
    logic        start;
    logic [7:0]  b;
  } feed_t;

  // directed rows: byte, block start, record count, overflow expected on this byte
  typedef struct packed {
    logic [7:0]  b;
    logic        start;
    logic [31:0] recs;
    logic        ovf_here;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bsml_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bsml_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;

  bitmap_sparse_memory_loader dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // directed part: stray bytes, an empty block, all-ones base with a huge span
  // (overflow, rest of block skipped), then a block ended by a zero base
  dir_row_t dir_tab [DirRows] = '{
    '{8'hAA, 1'b0, 32'h0000_0000, 1'b0},  // outside any block
    '{8'h5A, 1'b1, 32'h0000_0000, 1'b0},  // zero record count
    '{8'h00, 1'b0, 32'hFFFF_FFFF, 1'b0},  // still idle
    '{8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0},  // base byte 0, max record count
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b0},  // base all ones
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},  // span byte 0
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, 32'h0000_0000, 1'b1},  // span top byte: bitmap far too long
    '{8'h3C, 1'b0, 32'h0000_0000, 1'b0},  // skipped
    '{8'h00, 1'b1, 32'h0000_0002, 1'b0},  // new block, zero base follows
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b0, 32'h0000_0000, 1'b0},  // zero base ends the block
    '{8'h77, 1'b0, 32'h0000_0000, 1'b0}   // ignored
  };

  feed_t       byte_feed [$];  // every byte to be sent, in order
  write_t      write_q   [$];  // writes still owed by the block
  int unsigned live_bytes;     // bytes of generated records that go through the parser
  int unsigned feed_idx;       // next byte to put on s_axis
  int unsigned taken_cnt;      // bytes accepted by the block
  int unsigned writes_seen;
  int unsigned quiet_cycles;
  int unsigned fail_cnt;
  logic        hold_off = 1'b0;
  logic        calm = 1'b0;

  // loader model state
  load_phase_e phase;
  logic [63:0] asm_word;
  int unsigned asm_cnt;
  logic [63:0] rec_base;
  int unsigned map_len;
  logic [7:0]  map_mem [bsml_pkg::MaxMapBytes];
  int unsigned scan_byte;
  int unsigned scan_bit;
  logic [31:0] recs_left;

  // -------------------------------------------------------------------------
  // loader model
  // -------------------------------------------------------------------------

  // move the scan position to the next set bitmap bit at or after (from_byte, from_bit)
  function automatic bit seek_bit(input int unsigned from_byte, input int unsigned from_bit);
    int unsigned by;
    int unsigned bi;
    by = from_byte;
    bi = from_bit;
    while (by < map_len) begin
      while (bi < 8) begin
        if (map_mem[by][bi]) begin
          scan_byte = by;
          scan_bit  = bi;
          return 1'b1;
        end
        bi++;
      end
      bi = 0;
      by++;
    end
    return 1'b0;
  endfunction

  function automatic void close_record();
    if (recs_left != 0) recs_left--;
    phase = (recs_left != 0) ? LP_ADDR : LP_IDLE;
  endfunction

  task automatic predict_write(input logic [7:0] b, input logic start, input logic [31:0] recs,
                               output bit has, output write_t res);
    logic [63:0] word;
    has = 1'b0;
    res = '0;
    if (start) begin
      recs_left = recs;
      asm_word  = '0;
      asm_cnt   = 0;
      phase     = (recs != 0) ? LP_ADDR : LP_IDLE;
    end
    if (phase == LP_IDLE) return;
    if (phase == LP_MAP) begin
      map_mem[scan_byte] = b;
      scan_byte++;
      if (scan_byte >= map_len) begin
        if (seek_bit(0, 0)) phase = LP_DATA;
        else close_record();
      end
      return;
    end
    // address, span and data words come in little-endian
    asm_word[8*asm_cnt +: 8] = b;
    asm_cnt++;
    if (asm_cnt < 8) return;
    word     = asm_word;
    asm_word = '0;
    asm_cnt  = 0;
    case (phase)
      LP_ADDR: begin
        if (word == 64'd0) phase = LP_IDLE;
        else begin
          rec_base = word;
          phase    = LP_SPAN;
        end
      end
      LP_SPAN: begin
        if ((word >> 6) > 64'(bsml_pkg::MaxMapBytes)) begin
          phase   = LP_IDLE;
          res.ovf = 1'b1;
          has     = 1'b1;
        end else begin
          map_len   = int'(word >> 6);
          scan_byte = 0;
          scan_bit  = 0;
          if (map_len == 0) close_record();
          else phase = LP_MAP;
        end
      end
      LP_DATA: begin
        res.addr = rec_base + 64'(scan_byte) * 64'd64 + 64'(scan_bit) * 64'd8;
        res.data = word;
        has      = 1'b1;
        if (!seek_bit(scan_byte, scan_bit + 1)) close_record();
      end
      default: phase = LP_IDLE;
    endcase
  endtask

  // -------------------------------------------------------------------------
  // stream generator
  // -------------------------------------------------------------------------

  task automatic put_item(input logic [7:0] b, input logic start, input logic [31:0] recs);
    feed_t f;
    f       = '0;
    f.b     = b;
    f.start = start;
    // the record count is don't-care off a block start, so it carries noise there
    f.recs  = start ? recs : 32'($urandom());
    byte_feed.push_back(f);
  endtask

  task automatic put_noise(input int unsigned cnt);
    for (int i = 0; i < cnt; i++) put_item(8'($urandom()), 1'b0, 32'd0);
  endtask

  function automatic logic [7:0] map_byte(input map_fill_e fill, input int unsigned idx,
                                          input int unsigned len);
    case (fill)
      FILL_ZERO:   return 8'h00;
      FILL_ONES:   return 8'hFF;
      FILL_SPARSE: return 8'($urandom() & $urandom() & $urandom());
      FILL_ENDS:   return (idx == 0) ? 8'h01 : (idx == len - 1) ? 8'h80 : 8'h00;
      default:     return 8'($urandom());
    endcase
  endfunction

  // one record: base, span, bitmap and one data word per set bit; cut < 0 sends all of it,
  // otherwise only the first cut bytes go out
  task automatic put_record(input logic start, input logic [31:0] recs, input logic [63:0] base,
                            input logic [63:0] span, input map_fill_e fill, input int cut);
    logic [7:0]  rec_bytes [$];
    logic [7:0]  map_q [$];
    int unsigned len;
    logic [7:0]  mb;
    for (int i = 0; i < 8; i++) rec_bytes.push_back(base[8*i +: 8]);
    for (int i = 0; i < 8; i++) rec_bytes.push_back(span[8*i +: 8]);
    if ((span >> 6) <= 64'(bsml_pkg::MaxMapBytes)) begin
      len = int'(span >> 6);
      for (int i = 0; i < len; i++) begin
        mb = map_byte(fill, i, len);
        map_q.push_back(mb);
        rec_bytes.push_back(mb);
      end
      foreach (map_q[i])
        for (int k = 0; k < 8; k++)
          if (map_q[i][k])
            for (int j = 0; j < 8; j++) rec_bytes.push_back(8'($urandom()));
    end
    foreach (rec_bytes[i]) begin
      if (cut >= 0 && i >= cut) break;
      put_item(rec_bytes[i], start && (i == 0), recs);
      live_bytes++;
    end
  endtask

  function automatic logic [63:0] rand_base();
    logic [63:0] base;
    base = {32'($urandom()), 32'($urandom())};
    // some bases sit near the top so the write address wraps
    if ($urandom_range(99) < 15) base[63:12] = '1;
    if (base == 64'd0) base = 64'd1;
    return base;
  endfunction

  function automatic logic [63:0] rand_span();
    if ($urandom_range(99) < 8) return 64'($urandom_range(63));
    return 64'($urandom_range(1, 16)) * 64'd64 + 64'($urandom_range(63));
  endfunction

  function automatic map_fill_e rand_fill();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return FILL_RAND;
    if (pick < 70) return FILL_SPARSE;
    if (pick < 85) return FILL_ZERO;
    return FILL_ONES;
  endfunction

  task automatic put_block();
    int unsigned kind;
    int unsigned nrec;
    logic [31:0] recs;
    logic [63:0] span;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // well-formed block, sometimes with a count larger than the records sent
      nrec = $urandom_range(1, 4);
      case ($urandom_range(2))
        0:       recs = nrec;
        1:       recs = nrec + $urandom_range(1, 3);
        default: recs = 32'($urandom()) | 32'h100;
      endcase
      for (int r = 0; r < nrec; r++)
        put_record(r == 0, recs, rand_base(), rand_span(), rand_fill(), -1);
      // zero base ends the block early, leftover bytes are ignored
      if (recs > nrec && $urandom_range(1)) begin
        for (int i = 0; i < 8; i++) put_item(8'h00, 1'b0, 32'd0);
        put_noise($urandom_range(3));
      end
    end else if (kind < 78) begin
      // bitmap longer than the store
      span = {32'($urandom()), 32'($urandom())} | 64'h0100_0000;
      if ($urandom_range(1))
        span = 64'(bsml_pkg::MaxMapBytes + 1) * 64'd64 + 64'($urandom_range(63));
      put_record(1'b1, $urandom_range(1, 3), rand_base(), span, FILL_RAND, -1);
      put_noise($urandom_range(5));
    end else if (kind < 86) begin
      // record cut short, the next block start abandons it
      put_record(1'b1, $urandom_range(1, 3), rand_base(), rand_span(), rand_fill(),
                 $urandom_range(1, 40));
    end else if (kind < 92) begin
      put_item(8'($urandom()), 1'b1, 32'd0);
      put_noise($urandom_range(4));
    end else begin
      put_noise($urandom_range(1, 6));
    end
  endtask

  // -------------------------------------------------------------------------
  // driving
  // -------------------------------------------------------------------------

  // sender: idles about a third of the time outside the calm window
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      feed_idx      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (feed_idx < byte_feed.size() && (calm || $urandom_range(99) >= 34)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {byte_feed[feed_idx].recs, byte_feed[feed_idx].b};
        s_axis_tuser  <= byte_feed[feed_idx].start;
        feed_idx      <= feed_idx + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: same idling, plus the long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 34);
  end

  // calm window: no idling on either side for a while
  initial begin
    repeat (300) @(posedge clk_i);
    calm <= 1'b1;
    repeat (500) @(posedge clk_i);
    calm <= 1'b0;
  end

  // back-pressure: once writes flow, the receiver stops long enough for the input to stall
  initial begin
    while (writes_seen < 20) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // -------------------------------------------------------------------------
  // checking
  // -------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input write_t want, input write_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch (%0s) at %0t: want addr %h data %h ovf %b, got addr %h data %h ovf %b",
               what, $realtime, want.addr, want.data, want.ovf, got.addr, got.data, got.ovf);
  endtask

  always @(posedge clk_i) begin
    write_t got;
    write_t res;
    bit     has;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr = m_axis_tdata[63:0];
        got.data = m_axis_tdata[127:64];
        got.ovf  = m_axis_tuser;
        writes_seen++;
        if (write_q.size() == 0) begin
          flag_mismatch("no write owed", '0, got);
        end else begin
          res = write_q.pop_front();
          if (got.addr !== res.addr || got.data !== res.data || got.ovf !== res.ovf)
            flag_mismatch("field", res, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_write(byte_feed[taken_cnt].b, byte_feed[taken_cnt].start,
                      byte_feed[taken_cnt].recs, has, res);
        // typed-in rows override the model
        if (byte_feed[taken_cnt].typed) begin
          has = 1'b1;
          res = byte_feed[taken_cnt].want;
        end
        if (has) write_q.push_back(res);
        taken_cnt++;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------

  initial begin
    feed_t f;
    live_bytes   = 0;
    taken_cnt    = 0;
    writes_seen  = 0;
    quiet_cycles = 0;
    fail_cnt     = 0;
    phase        = LP_IDLE;
    asm_word     = '0;
    asm_cnt      = 0;
    rec_base     = '0;
    map_len      = 0;
    scan_byte    = 0;
    scan_bit     = 0;
    recs_left    = '0;

    // directed table
    foreach (dir_tab[i]) begin
      f       = '0;
      f.b     = dir_tab[i].b;
      f.start = dir_tab[i].start;
      f.recs  = dir_tab[i].recs;
      if (dir_tab[i].ovf_here) begin
        f.typed    = 1'b1;
        f.want.ovf = 1'b1;
      end
      byte_feed.push_back(f);
    end

    // shaped records first: address wrap, short span, empty bitmap,
    // block start in the middle of a record and of a bitmap, set bits only at the map ends
    put_record(1'b1, 32'd1, 64'hFFFF_FFFF_FFFF_FF80, 64'd192, FILL_ONES, -1);
    put_record(1'b1, 32'd2, rand_base(), 64'($urandom_range(63)), FILL_RAND, -1);
    put_record(1'b0, 32'd2, rand_base(), 64'd256, FILL_ZERO, -1);
    put_record(1'b1, 32'd1, rand_base(), 64'd128, FILL_ONES, 12);
    put_record(1'b1, 32'd1, rand_base(), 64'd320, FILL_RAND, 18);
    put_record(1'b1, 32'd1, rand_base(), 64'd128, FILL_SPARSE, -1);
    put_record(1'b1, 32'd1, rand_base(), 64'd1024, FILL_ENDS, -1);

    while (live_bytes < LiveTarget) put_block();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (taken_cnt < byte_feed.size() || write_q.size() != 0) @(posedge clk_i);
    // room for a stray write after the last one owed
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
